// File: hw/rtl/fts_pkg.sv
// Shared types, codes and tables for the formula token scanner.
`default_nettype none
package fts_pkg;

  localparam int NAME_CHARS_MAX = 32;
  localparam int NAME_IDX_W     = $clog2(NAME_CHARS_MAX);
  localparam int NAME_LEN_W     = $clog2(NAME_CHARS_MAX + 1);

  localparam logic [30:0] MAX_CONST = 31'h7FFF_FFFF;
  localparam logic [15:0] SAT16     = 16'hFFFF;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;

  // token kinds
  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_BANG    = 5'd10;
  localparam logic [4:0] K_GT      = 5'd12;
  localparam logic [4:0] K_LT      = 5'd14;
  localparam logic [4:0] K_NEQ     = 5'd22;
  localparam logic [4:0] K_CONST   = 5'd23;
  localparam logic [4:0] K_NAME    = 5'd24;
  localparam logic [4:0] K_ERROR   = 5'd25;
  localparam logic [4:0] K_LAST    = 5'd25;

  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_CHAR    = 2'd1;
  localparam logic [1:0] E_RANGE   = 2'd2;
  localparam logic [1:0] E_COMMENT = 2'd3;

  localparam int KW_COUNT = 6;

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_OP      = 8'b0000_0010,
    M_SLASH   = 8'b0000_0100,
    M_COMMENT = 8'b0000_1000,
    M_STAR    = 8'b0001_0000,
    M_NUMBER  = 8'b0010_0000,
    M_NAME    = 8'b0100_0000,
    M_ERROR   = 8'b1000_0000
  } mode_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b000_0001,
    S_FIRST  = 7'b000_0010,
    S_NREAD  = 7'b000_0100,
    S_NEMIT  = 7'b000_1000,
    S_SECOND = 7'b001_0000,
    S_APPLY  = 7'b010_0000,
    S_SPARE  = 7'b100_0000
  } ctrl_state_t;

  typedef enum logic [1:0] {
    F_NONE = 2'd0,
    F_ONE  = 2'd1,
    F_RUN  = 2'd2
  } first_sel_t;

  typedef struct packed {
    logic accept;
    logic load_first;
    logic name_clr;
    logic name_rd;
    logic load_name;
    logic load_second;
    logic apply;
  } cmd_t;

  typedef struct packed {
    first_sel_t first_sel;
    logic       second_valid;
    logic       name_last;
    logic       out_free;
  } status_t;

  function automatic logic [2:0] kw_len(input int k);
    case (k)
      0: kw_len = 3'd3;
      1: kw_len = 3'd2;
      2: kw_len = 3'd3;
      3: kw_len = 3'd6;
      4: kw_len = 3'd6;
      default: kw_len = 3'd3;
    endcase
  endfunction

  // lower-case keyword text: and, or, not, exists, forall, mod
  function automatic logic [7:0] kw_char(input int k, input int i);
    logic [47:0] s;
    case (k)
      0: s = {"and", 24'd0};
      1: s = {"or", 32'd0};
      2: s = {"not", 24'd0};
      3: s = "exists";
      4: s = "forall";
      default: s = {"mod", 24'd0};
    endcase
    kw_char = s[47 - 8*i -: 8];
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    case (c)
      8'h3A: punct_kind = 5'd7;
      8'h2C: punct_kind = 5'd8;
      8'h3D: punct_kind = 5'd9;
      8'h7B: punct_kind = 5'd15;
      8'h28: punct_kind = 5'd16;
      8'h7D: punct_kind = 5'd17;
      8'h29: punct_kind = 5'd18;
      8'h2D: punct_kind = 5'd19;
      8'h2B: punct_kind = 5'd20;
      8'h2A: punct_kind = 5'd21;
      default: punct_kind = K_END;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/fts_ctrl.sv
// Sequencer of the token scanner: accept, emit results, commit state.
`default_nettype none
module fts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  fts_pkg::status_t     status,
  output fts_pkg::cmd_t        cmd
);
  import fts_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        case (status.first_sel)
          F_ONE: begin
            if (status.out_free) begin
              cmd.load_first = 1'b1;
              state_next     = S_SECOND;
            end
          end
          F_RUN: begin
            cmd.name_clr = 1'b1;
            state_next   = S_NREAD;
          end
          default: state_next = S_SECOND;
        endcase
      end
      S_NREAD: begin
        cmd.name_rd = 1'b1;
        state_next  = S_NEMIT;
      end
      S_NEMIT: begin
        if (status.out_free) begin
          cmd.load_name = 1'b1;
          state_next    = status.name_last ? S_SECOND : S_NREAD;
        end
      end
      S_SECOND: begin
        if (!status.second_valid) begin
          state_next = S_APPLY;
        end else if (status.out_free) begin
          cmd.load_second = 1'b1;
          state_next      = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/fts_datapath.sv
// Scanner state, name buffer, token planning and the result register.
`default_nettype none
module fts_datapath (
  input  wire logic         clk,
  input  wire logic         rst,
  input  fts_pkg::cmd_t     cmd,
  output fts_pkg::status_t  status,
  input  wire logic [7:0]   char_code,
  input  wire logic         end_of_input,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [4:0]        token_kind,
  output logic [30:0]       const_value,
  output logic [7:0]        name_char,
  output logic [15:0]       token_line,
  output logic [15:0]       token_column,
  output logic [1:0]        error_code,
  output logic              last_of_token
);
  import fts_pkg::*;

  mode_t                   mode, mode_next;
  logic [7:0]              c;
  logic                    eoi;
  logic [NAME_LEN_W-1:0]   name_len, name_len_next;
  logic [NAME_LEN_W-1:0]   name_idx;
  logic [30:0]             acc, acc_next;
  logic [15:0]             line_cnt, col_cnt, start_line, start_col;
  logic [15:0]             start_line_next, start_col_next;
  logic [KW_COUNT-1:0]     kw_lo, kw_up, kw_lo_next, kw_up_next;
  logic [7:0]              name_mem [NAME_CHARS_MAX];
  logic [7:0]              rd_data;
  logic                    wr_en;
  logic [NAME_IDX_W-1:0]   wr_idx;
  logic [NAME_LEN_W-1:0]   kw_idx;

  logic                    digit_ch, alpha_ch, is_blank, name_ch, go_idle;
  logic [34:0]             acc_x10;
  logic                    overflow;
  logic [4:0]              kw_kind, pk;
  logic [15:0]             col_p1;

  first_sel_t              first_sel;
  logic [4:0]              f_kind;
  logic [30:0]             f_cval;
  logic [1:0]              f_err;
  logic                    s_valid;
  logic [4:0]              s_kind;
  logic [15:0]             s_line, s_col;
  logic [1:0]              s_err;

  assign digit_ch = (c inside {[CH_0:CH_9]});
  assign alpha_ch = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_US});
  assign is_blank = (c inside {CH_SPACE, CH_TAB, CH_CR, CH_NL});
  assign name_ch  = alpha_ch || digit_ch || (c == CH_DOT);
  assign pk       = punct_kind(c);
  assign acc_x10  = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {27'd0, c - CH_0};
  assign overflow = acc_x10 > {4'd0, MAX_CONST};
  assign col_p1   = (col_cnt != SAT16) ? col_cnt + 16'd1 : SAT16;

  always_comb begin
    kw_kind = K_END;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (name_len == NAME_LEN_W'(kw_len(k)) && (kw_lo[k] || kw_up[k])) begin
        kw_kind = 5'(k + 1);
      end
    end
  end

  // plan of the results for the held item
  always_comb begin
    first_sel = F_NONE;
    f_kind    = K_END;
    f_cval    = '0;
    f_err     = E_NONE;
    go_idle   = 1'b0;
    if (eoi) begin
      case (mode)
        M_OP:      begin first_sel = F_ONE; f_kind = acc[4:0]; end
        M_SLASH:   begin first_sel = F_ONE; f_kind = K_ERROR; f_err = E_CHAR; end
        M_COMMENT,
        M_STAR:    begin first_sel = F_ONE; f_kind = K_ERROR; f_err = E_COMMENT; end
        M_NUMBER:  begin first_sel = F_ONE; f_kind = K_CONST; f_cval = acc; end
        M_NAME: begin
          if (kw_kind != K_END) begin
            first_sel = F_ONE;
            f_kind    = kw_kind;
          end else begin
            first_sel = F_RUN;
          end
        end
        default: ;
      endcase
    end else begin
      case (mode)
        M_IDLE: go_idle = 1'b1;
        M_SLASH: begin
          if (c != CH_STAR) begin
            first_sel = F_ONE; f_kind = K_ERROR; f_err = E_CHAR;
          end
        end
        M_OP: begin
          first_sel = F_ONE;
          if (c == CH_EQ) begin
            f_kind = (acc[4:0] == K_BANG) ? K_NEQ : acc[4:0] - 5'd1;
          end else begin
            f_kind  = acc[4:0];
            go_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (digit_ch) begin
            if (overflow) begin
              first_sel = F_ONE; f_kind = K_ERROR; f_err = E_RANGE;
            end
          end else begin
            first_sel = F_ONE; f_kind = K_CONST; f_cval = acc; go_idle = 1'b1;
          end
        end
        M_NAME: begin
          if (!name_ch) begin
            go_idle = 1'b1;
            if (kw_kind != K_END) begin
              first_sel = F_ONE;
              f_kind    = kw_kind;
            end else begin
              first_sel = F_RUN;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // second result: end token or the single-byte token of an idle byte
  always_comb begin
    s_valid = 1'b0;
    s_kind  = K_END;
    s_line  = line_cnt;
    s_col   = col_cnt;
    s_err   = E_NONE;
    if (eoi) begin
      s_valid = 1'b1;
      s_col   = col_p1;
    end else if (go_idle) begin
      if (pk != K_END) begin
        s_valid = 1'b1;
        s_kind  = pk;
      end else if (!is_blank && !digit_ch && !alpha_ch &&
                   !(c inside {CH_BANG, CH_GT, CH_LT, CH_SLASH})) begin
        s_valid = 1'b1;
        s_kind  = K_ERROR;
        s_err   = E_CHAR;
      end
    end
  end

  // state after the held item
  always_comb begin
    mode_next       = mode;
    acc_next        = acc;
    name_len_next   = name_len;
    start_line_next = start_line;
    start_col_next  = start_col;
    wr_en           = 1'b0;
    wr_idx          = name_len[NAME_IDX_W-1:0];
    kw_idx          = name_len;
    case (mode)
      M_COMMENT: if (c == CH_STAR) mode_next = M_STAR;
      M_STAR: begin
        if (c == CH_SLASH) mode_next = M_IDLE;
        else if (c != CH_STAR) mode_next = M_COMMENT;
      end
      M_SLASH:  mode_next = (c == CH_STAR) ? M_COMMENT : M_ERROR;
      M_OP:     mode_next = M_IDLE;
      M_NUMBER: begin
        if (digit_ch) begin
          if (overflow) mode_next = M_ERROR;
          else acc_next = acc_x10[30:0];
        end
      end
      M_NAME: begin
        if (name_ch && name_len < NAME_LEN_W'(NAME_CHARS_MAX)) begin
          wr_en         = 1'b1;
          name_len_next = name_len + 1'b1;
        end
      end
      default: ;
    endcase
    if (go_idle) begin
      mode_next = M_IDLE;
      if (pk == K_END && !is_blank) begin
        start_line_next = line_cnt;
        start_col_next  = col_cnt;
        if (c == CH_BANG) begin
          mode_next = M_OP; acc_next = 31'(K_BANG);
        end else if (c == CH_GT) begin
          mode_next = M_OP; acc_next = 31'(K_GT);
        end else if (c == CH_LT) begin
          mode_next = M_OP; acc_next = 31'(K_LT);
        end else if (c == CH_SLASH) begin
          mode_next = M_SLASH;
        end else if (digit_ch) begin
          mode_next = M_NUMBER; acc_next = {23'd0, c - CH_0};
        end else if (alpha_ch) begin
          mode_next     = M_NAME;
          wr_en         = 1'b1;
          wr_idx        = '0;
          kw_idx        = '0;
          name_len_next = NAME_LEN_W'(1);
        end else begin
          mode_next = M_ERROR;
        end
      end
    end
  end

  // keyword match flags, kept as characters are stored
  always_comb begin
    kw_lo_next = kw_lo;
    kw_up_next = kw_up;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (kw_idx == '0) begin
        kw_lo_next[k] = (c == kw_char(k, 0));
        kw_up_next[k] = (c == kw_char(k, 0) - 8'd32);
      end else if (kw_idx < NAME_LEN_W'(kw_len(k))) begin
        kw_lo_next[k] = kw_lo[k] && (c == kw_char(k, int'(kw_idx)));
        kw_up_next[k] = kw_up[k] && (c == kw_char(k, int'(kw_idx)) - 8'd32);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      name_len   <= '0;
      acc        <= '0;
      line_cnt   <= 16'd1;
      col_cnt    <= '0;
      start_line <= 16'd1;
      start_col  <= '0;
    end else if (cmd.accept) begin
      if (!end_of_input) begin
        if (char_code == CH_NL) begin
          if (line_cnt != SAT16) line_cnt <= line_cnt + 16'd1;
          col_cnt <= '0;
        end else if (col_cnt != SAT16) begin
          col_cnt <= col_cnt + 16'd1;
        end
      end
    end else if (cmd.apply) begin
      if (eoi) begin
        mode       <= M_IDLE;
        name_len   <= '0;
        acc        <= '0;
        line_cnt   <= 16'd1;
        col_cnt    <= '0;
        start_line <= 16'd1;
        start_col  <= '0;
      end else begin
        mode       <= mode_next;
        name_len   <= name_len_next;
        acc        <= acc_next;
        start_line <= start_line_next;
        start_col  <= start_col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c   <= char_code;
      eoi <= end_of_input;
    end
    if (cmd.apply && !eoi && wr_en) begin
      name_mem[wr_idx] <= c;
      kw_lo            <= kw_lo_next;
      kw_up            <= kw_up_next;
    end
    if (cmd.name_rd) begin
      rd_data <= name_mem[name_idx[NAME_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_idx <= '0;
    end else if (cmd.name_clr) begin
      name_idx <= '0;
    end else if (cmd.load_name) begin
      name_idx <= name_idx + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_first || cmd.load_second || cmd.load_name) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      token_kind    <= f_kind;
      const_value   <= f_cval;
      name_char     <= '0;
      token_line    <= start_line;
      token_column  <= start_col;
      error_code    <= f_err;
      last_of_token <= 1'b1;
    end else if (cmd.load_name) begin
      token_kind    <= K_NAME;
      const_value   <= '0;
      name_char     <= rd_data;
      token_line    <= start_line;
      token_column  <= start_col;
      error_code    <= E_NONE;
      last_of_token <= status.name_last;
    end else if (cmd.load_second) begin
      token_kind    <= s_kind;
      const_value   <= '0;
      name_char     <= '0;
      token_line    <= s_line;
      token_column  <= s_col;
      error_code    <= s_err;
      last_of_token <= 1'b1;
    end
  end

  assign status.first_sel    = first_sel;
  assign status.second_valid = s_valid;
  assign status.name_last    = (name_idx + 1'b1) == name_len;
  assign status.out_free     = !out_valid || !out_stall;
endmodule
`default_nettype wire

// File: hw/rtl/formula_token_scanner_top.sv
// Top level of the formula token scanner: sequencer plus datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | sink      | in_valid/in_stall  | char_code, end_of_input
//  out     | source    | out_valid/out_stall| token_kind .. last_of_token
//
// Each input transaction runs through accept, first result, second result and
// commit, with a read and an emit step per character of a name run (the name
// buffer read is registered), and waits while a result is held on out_stall.
// The sequencer in fts_ctrl runs these steps: accept, plan, emit, commit.
// Reset (rst, synchronous) returns to line 1, column 0, idle scanning.
// A stalled output holds the result register; the sequencer waits on it.
// End-of-input emits any pending token, then the end token, and restarts.
`default_nettype none
module formula_token_scanner_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       token_kind,
  output logic [30:0]      const_value,
  output logic [7:0]       name_char,
  output logic [15:0]      token_line,
  output logic [15:0]      token_column,
  output logic [1:0]       error_code,
  output logic             last_of_token
);
  import fts_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller: one transaction at a time
  fts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: scan state, name buffer, result register
  fts_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .char_code     (char_code),
    .end_of_input  (end_of_input),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_kind    (token_kind),
    .const_value   (const_value),
    .name_char     (name_char),
    .token_line    (token_line),
    .token_column  (token_column),
    .error_code    (error_code),
    .last_of_token (last_of_token)
  );
endmodule
`default_nettype wire

// File: hw/rtl/fts_checker.sv
// Port-level checks on the token scanner, bound to the top level.
`default_nettype none
module fts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [4:0]  token_kind,
  input wire logic [30:0] const_value,
  input wire logic [1:0]  error_code,
  input wire logic        last_of_token
);
  import fts_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= K_LAST)
    else $error("token kind out of range");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != K_ERROR |-> error_code == E_NONE)
    else $error("error code on non-error token");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != K_NAME |-> last_of_token)
    else $error("single token not marked last");

  a_cval: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != K_CONST |-> const_value == '0)
    else $error("constant value on non-constant token");
endmodule

bind formula_token_scanner_top fts_checker u_fts_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .token_kind    (token_kind),
  .const_value   (const_value),
  .error_code    (error_code),
  .last_of_token (last_of_token)
);
`default_nettype wire

// File: tb/formula_token_scanner_checker.sv
// Scoreboard for the formula token scanner: predicts tokens and compares them.
module formula_token_scanner_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        end_of_input,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [4:0]  token_kind,
  input  wire logic [30:0] const_value,
  input  wire logic [7:0]  name_char,
  input  wire logic [15:0] token_line,
  input  wire logic [15:0] token_column,
  input  wire logic [1:0]  error_code,
  input  wire logic        last_of_token,
  output int               fail_count,
  output int               pending
);
  import fts_pkg::*;

  typedef struct packed {
    logic [4:0]  kind;
    logic [30:0] cval;
    logic [7:0]  ch;
    logic [15:0] line;
    logic [15:0] col;
    logic [1:0]  err;
    logic        last;
  } token_t;

  typedef enum int {
    SC_IDLE, SC_OP, SC_SLASH, SC_COMMENT, SC_STAR, SC_NUMBER, SC_NAME, SC_ERROR
  } scan_t;

  token_t      token_q[$];
  scan_t       mode;
  logic [7:0]  name_buf[NAME_CHARS_MAX];
  int          name_len;
  logic [30:0] acc;
  logic [15:0] line_cnt, col_cnt, start_line, start_col;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  task automatic clear_state();
    mode = SC_IDLE;
    name_len = 0;
    acc = '0;
    line_cnt = 16'd1;
    col_cnt = '0;
    start_line = 16'd1;
    start_col = '0;
  endtask

  task automatic push_token(logic [4:0] kind, logic [30:0] cval, logic [7:0] ch,
                            logic [15:0] ln, logic [15:0] cl, logic [1:0] err,
                            logic last);
    token_q.push_back('{kind, cval, ch, ln, cl, err, last});
  endtask

  // keyword match: all lower or all upper case
  task automatic emit_name();
    string words[6] = '{"and", "or", "not", "exists", "forall", "mod"};
    int hit;
    logic lo, up;
    logic [7:0] w;
    hit = 0;
    for (int k = 0; k < 6 && hit == 0; k++) begin
      if (words[k].len() == name_len) begin
        lo = 1'b1;
        up = 1'b1;
        for (int i = 0; i < name_len; i++) begin
          w = words[k][i];
          if (name_buf[i] != w) lo = 1'b0;
          if (name_buf[i] != w - 8'd32) up = 1'b0;
        end
        if (lo || up) hit = k + 1;
      end
    end
    if (hit != 0) begin
      push_token(5'(hit), '0, '0, start_line, start_col, E_NONE, 1'b1);
    end else begin
      for (int i = 0; i < name_len; i++)
        push_token(K_NAME, '0, name_buf[i], start_line, start_col, E_NONE,
                   i + 1 == name_len);
    end
  endtask

  task automatic scan_fresh(logic [7:0] c);
    logic [4:0] pk;
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL) return;
    pk = punct_kind(c);
    if (pk != K_END) begin
      push_token(pk, '0, '0, line_cnt, col_cnt, E_NONE, 1'b1);
      return;
    end
    start_line = line_cnt;
    start_col = col_cnt;
    if (c == CH_BANG || c == CH_GT || c == CH_LT) begin
      acc = (c == CH_BANG) ? 31'(K_BANG) : (c == CH_GT) ? 31'(K_GT) : 31'(K_LT);
      mode = SC_OP;
    end else if (c == CH_SLASH) begin
      mode = SC_SLASH;
    end else if (is_num(c)) begin
      acc = 31'(c - CH_0);
      mode = SC_NUMBER;
    end else if (is_letter(c)) begin
      name_buf[0] = c;
      name_len = 1;
      mode = SC_NAME;
    end else begin
      push_token(K_ERROR, '0, '0, line_cnt, col_cnt, E_CHAR, 1'b1);
      mode = SC_ERROR;
    end
  endtask

  task automatic predict_tokens(logic [7:0] c, logic eoi);
    logic [34:0] v;
    logic [4:0] k;
    if (eoi) begin
      case (mode)
        SC_OP:     push_token(5'(acc), '0, '0, start_line, start_col, E_NONE, 1'b1);
        SC_SLASH:  push_token(K_ERROR, '0, '0, start_line, start_col, E_CHAR, 1'b1);
        SC_COMMENT, SC_STAR:
          push_token(K_ERROR, '0, '0, start_line, start_col, E_COMMENT, 1'b1);
        SC_NUMBER: push_token(K_CONST, acc, '0, start_line, start_col, E_NONE, 1'b1);
        SC_NAME:   emit_name();
        default: ;
      endcase
      push_token(K_END, '0, '0, line_cnt, (col_cnt == SAT16) ? SAT16 : col_cnt + 16'd1,
                 E_NONE, 1'b1);
      clear_state();
      return;
    end
    if (c == CH_NL) begin
      if (line_cnt != SAT16) line_cnt++;
      col_cnt = '0;
    end else if (col_cnt != SAT16) begin
      col_cnt++;
    end
    case (mode)
      SC_ERROR: return;
      SC_COMMENT: begin
        if (c == CH_STAR) mode = SC_STAR;
        return;
      end
      SC_STAR: begin
        if (c == CH_SLASH) mode = SC_IDLE;
        else if (c != CH_STAR) mode = SC_COMMENT;
        return;
      end
      SC_SLASH: begin
        if (c == CH_STAR) begin
          mode = SC_COMMENT;
        end else begin
          push_token(K_ERROR, '0, '0, start_line, start_col, E_CHAR, 1'b1);
          mode = SC_ERROR;
        end
        return;
      end
      SC_OP: begin
        mode = SC_IDLE;
        if (c == CH_EQ) begin
          k = (acc == 31'(K_BANG)) ? K_NEQ : 5'(acc) - 5'd1;
          push_token(k, '0, '0, start_line, start_col, E_NONE, 1'b1);
          return;
        end
        push_token(5'(acc), '0, '0, start_line, start_col, E_NONE, 1'b1);
      end
      SC_NUMBER: begin
        if (is_num(c)) begin
          v = 35'(acc) * 35'd10 + 35'(c - CH_0);
          if (v > 35'(MAX_CONST)) begin
            push_token(K_ERROR, '0, '0, start_line, start_col, E_RANGE, 1'b1);
            mode = SC_ERROR;
          end else begin
            acc = v[30:0];
          end
          return;
        end
        push_token(K_CONST, acc, '0, start_line, start_col, E_NONE, 1'b1);
        mode = SC_IDLE;
      end
      SC_NAME: begin
        if (is_letter(c) || is_num(c) || c == CH_DOT) begin
          if (name_len < NAME_CHARS_MAX) begin
            name_buf[name_len] = c;
            name_len++;
          end
          return;
        end
        emit_name();
        mode = SC_IDLE;
      end
      default: ;
    endcase
    scan_fresh(c);
  endtask

  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    clear_state();
  end

  always @(posedge clk) begin
    token_t e;
    if (rst) begin
      clear_state();
    end else begin
      if (in_valid && !in_stall) predict_tokens(char_code, end_of_input);
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("token with none expected: kind %0d", token_kind);
          fail_count++;
        end else begin
          e = token_q.pop_front();
          check_field("token_kind", e.kind, token_kind);
          check_field("const_value", e.cval, const_value);
          check_field("name_char", e.ch, name_char);
          check_field("token_line", e.line, token_line);
          check_field("token_column", e.col, token_column);
          check_field("error_code", e.err, error_code);
          check_field("last_of_token", e.last, last_of_token);
        end
      end
    end
    pending = token_q.size();
  end

endmodule

// File: tb/formula_token_scanner_top_tb.sv
// Stimulus and verdict for the formula token scanner.
module formula_token_scanner_top_tb;
  import fts_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = '0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  token_kind;
  logic [30:0] const_value;
  logic [7:0]  name_char;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [1:0]  error_code;
  logic        last_of_token;
  int          fail_count;
  int          pending;

  // source bytes; value 256 stands for an end-of-input mark
  int unsigned src_q[$];
  bit          feeding_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  formula_token_scanner_top dut (.*);

  formula_token_scanner_checker scoreboard (.*);

  // mostly short gaps, once in a while a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  task automatic add_eoi();
    src_q.push_back(256);
  endtask

  function automatic string rand_name(int len);
    string s;
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789.";
    s = "";
    s = {s, string'(pool[$urandom_range(0, 52)])};
    for (int i = 1; i < len; i++) s = {s, string'(pool[$urandom_range(0, 63)])};
    return s;
  endfunction

  // one random lexeme, mostly well formed
  function automatic string rand_lexeme();
    string kws[12] = '{"and", "or", "not", "exists", "forall", "mod",
                       "AND", "OR", "NOT", "EXISTS", "FORALL", "MOD"};
    string ops[16] = '{":", ",", "=", "{", "(", "}", ")", "-", "+", "*",
                       ">=", "<=", "!=", ">", "<", "!"};
    case ($urandom_range(0, 9))
      0, 1: return rand_name($urandom_range(1, 6));
      2: return kws[$urandom_range(0, 11)];
      3, 4: return ops[$urandom_range(0, 15)];
      5: return $sformatf("%0d", $urandom_range(0, 99999));
      6: return $urandom_range(0, 1) ? "\n" : "\t";
      7: return "/* x*\n*/";
      8: return " ";
      default: return string'(8'($urandom_range(0, 255)));
    endcase
  endfunction

  task automatic build_stimulus();
    // directed: operators, pairs, keywords both cases, constant limits
    add_text(":,={(})-+*>=<=!=> < ! and OR not EXISTS forall MOD");
    add_text(" 0 2147483647 x_9.Y\r\n/* a * / ** */q");
    add_eoi();
    add_text("2147483648"); add_eoi();              // constant overflow
    add_text("/* open *"); add_eoi();              // unterminated comment
    add_text("a/b"); add_eoi();                    // lone slash
    add_text("/"); add_eoi();                      // slash at end
    add_text("#"); src_q.push_back(255); src_q.push_back(0); add_eoi();
    add_text("<"); add_eoi();                      // pending operator at end
    add_text(rand_name(40)); add_eoi();            // long identifier, truncated
    add_text("12"); add_eoi();
    // random formulas
    for (int f = 0; f < 2; f++) begin
      int n;
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) add_text({rand_lexeme(), " "});
      if ($urandom_range(0, 3) == 0) src_q.push_back($urandom_range(0, 255));
      add_eoi();
    end
  endtask

  // output stall pattern
  initial begin
    @(posedge clk iff !rst);
    forever begin
      repeat (gap_len()) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    int unsigned b;
    int          g;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (src_q.size() > 0) begin
      b = src_q.pop_front();
      g = gap_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      in_valid <= 1'b1;
      char_code <= (b == 256) ? 8'($urandom_range(0, 255)) : 8'(b);
      end_of_input <= (b == 256);
      @(posedge clk iff !in_stall);
    end
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    feeding_done = 1'b1;
  end

  // verdict
  initial begin
    wait (feeding_done);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard limit
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: formula_token_scanner_top.f
hw/rtl/fts_pkg.sv
hw/rtl/fts_ctrl.sv
hw/rtl/fts_datapath.sv
hw/rtl/formula_token_scanner_top.sv
hw/rtl/fts_checker.sv
tb/formula_token_scanner_checker.sv
tb/formula_token_scanner_top_tb.sv
